// ===== hw/rtl/srm_pkg.sv =====
package srm_pkg;

    localparam int MAX_SAMPLES = 16384;
    localparam int IDX_W       = 14;
    localparam int IDX_CAP_INT = (MAX_SAMPLES - 1 < 16383) ? MAX_SAMPLES - 1 : 16383;
    localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(IDX_CAP_INT);

    localparam int SAMPLE_W = 24;
    localparam int SP_W     = 18;
    localparam logic [SP_W-1:0] SP_RESET = 18'd65536;
    localparam logic [SAMPLE_W-1:0] PEAK_RESET = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // shared compare/subtract unit width, covers 50*sample and the dividend
    localparam int ALU_W = 40;
    localparam int NUM_W = 38;
    localparam int OVS_W = 16;
    localparam int SCALE_W = 14;
    localparam logic [SCALE_W-1:0] OVS_SCALE = 14'd10000;
    localparam int DIV_STEPS = 17;
    localparam int STEP_W    = 5;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 72;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOW,
        ST_HIGH,
        ST_OUT_HI,
        ST_OUT_LO,
        ST_PEAK,
        ST_OVS_CMP,
        ST_OVS_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OPS_LOW,
        OPS_HIGH,
        OPS_OUT_HI,
        OPS_OUT_LO,
        OPS_PEAK,
        OPS_OVS,
        OPS_DIV
    } opsel_t;

    typedef struct packed {
        opsel_t              opsel;
        logic                ready;
        logic                upd_low;
        logic                upd_high;
        logic                upd_out_hi;
        logic                upd_out_lo;
        logic                upd_peak;
        logic                ovs_cmp;
        logic                ovs_mul;
        logic                div_step;
        logic                load_out;
        logic [STEP_W-1:0]   step;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic final_flag;
        logic out_free;
    } stat_t;

endpackage

// ===== hw/rtl/srm_alu.sv =====
module srm_alu (
    input  logic [srm_pkg::ALU_W-1:0] op_a,
    input  logic [srm_pkg::ALU_W-1:0] op_b,
    output logic                      ge,
    output logic [srm_pkg::ALU_W-1:0] diff
);
    import srm_pkg::*;

    logic [ALU_W:0] full;

    // signed compare by the sign of the extended difference
    assign full = {op_a[ALU_W-1], op_a} - {op_b[ALU_W-1], op_b};
    assign ge   = ~full[ALU_W];
    assign diff = full[ALU_W-1:0];

endmodule

// ===== hw/rtl/srm_ctrl.sv =====
module srm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  srm_pkg::stat_t  stat,
    output srm_pkg::ctrl_t  ctrl
);
    import srm_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (stat.accept) state_next = ST_LOW;
            end
            ST_LOW:     state_next = ST_HIGH;
            ST_HIGH:    state_next = ST_OUT_HI;
            ST_OUT_HI:  state_next = ST_OUT_LO;
            ST_OUT_LO:  state_next = ST_PEAK;
            ST_PEAK:    state_next = stat.final_flag ? ST_OVS_CMP : ST_IDLE;
            ST_OVS_CMP: state_next = ST_OVS_MUL;
            ST_OVS_MUL: begin
                state_next = ST_DIV;
                step_next  = STEP_W'(DIV_STEPS - 1);
            end
            ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl       = '0;
        ctrl.opsel = OPS_LOW;
        ctrl.step  = step_reg;
        unique case (state_reg)
            ST_IDLE:    ctrl.ready = 1'b1;
            ST_LOW: begin
                ctrl.opsel   = OPS_LOW;
                ctrl.upd_low = 1'b1;
            end
            ST_HIGH: begin
                ctrl.opsel    = OPS_HIGH;
                ctrl.upd_high = 1'b1;
            end
            ST_OUT_HI: begin
                ctrl.opsel      = OPS_OUT_HI;
                ctrl.upd_out_hi = 1'b1;
            end
            ST_OUT_LO: begin
                ctrl.opsel      = OPS_OUT_LO;
                ctrl.upd_out_lo = 1'b1;
            end
            ST_PEAK: begin
                ctrl.opsel    = OPS_PEAK;
                ctrl.upd_peak = 1'b1;
            end
            ST_OVS_CMP: begin
                ctrl.opsel   = OPS_OVS;
                ctrl.ovs_cmp = 1'b1;
            end
            ST_OVS_MUL: ctrl.ovs_mul = 1'b1;
            ST_DIV: begin
                ctrl.opsel    = OPS_DIV;
                ctrl.div_step = 1'b1;
            end
            ST_DONE:    ctrl.load_out = stat.out_free;
            default:    ctrl.opsel = OPS_LOW;
        endcase
    end

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OVS_MUL) |=>
            (state_reg == ST_DIV) && (step_reg == STEP_W'(DIV_STEPS - 1)))
        else $error("divide did not start at the top quotient bit");

    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (step_reg < STEP_W'(DIV_STEPS)))
        else $error("divide step out of range");

endmodule

// ===== hw/rtl/step_response_metrics_core.sv =====
// channel  | dir | tvalid/tready | payload
// ---------+-----+---------------+--------------------------------------------------
// s_       | in  | request       | tdata: sample[23:0]; tlast: final_sample
// m_       | out | request       | tdata: rise, reached, settle, settled, peak, ovs
// cfg_     | in  | wr_en only    | wr_data: setpoint[17:0]
//
// a non-final sample holds the shared compare unit for the low, high, two band and
// peak compares; s_tready stays low until done. a final sample adds the overshoot
// compare, 17 divide steps on it and one multiply, plus any output register wait.
// aresetn (synchronous) clears the response state and sets the setpoint to 1.0.
// the output register lets a new response start while a result waits on m_tready.
module step_response_metrics_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srm_pkg::S_TDATA_W-1:0] s_tdata,   // [23:0] sample
    input  logic                          s_tlast,   // final_sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [13:0] rise_samples, [14] rise_reached, [28:15] settle_index, [29] settled,
    // [53:30] peak_value, [69:54] overshoot_centipercent, [71:70] zero
    output logic [srm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [srm_pkg::SP_W-1:0]      cfg_wr_data
);
    import srm_pkg::*;

    localparam logic [ALU_W-1:0] K9  = ALU_W'(9);
    localparam logic [ALU_W-1:0] K10 = ALU_W'(10);
    localparam logic [ALU_W-1:0] K49 = ALU_W'(49);
    localparam logic [ALU_W-1:0] K50 = ALU_W'(50);
    localparam logic [ALU_W-1:0] K51 = ALU_W'(51);

    ctrl_t ctrl;
    stat_t stat;

    logic [SP_W-1:0]      sp_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic                 final_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     low_idx_reg;
    logic                 low_seen_reg;
    logic [IDX_W-1:0]     high_idx_reg;
    logic                 high_seen_reg;
    logic [SAMPLE_W-1:0]  peak_reg;
    logic [IDX_W-1:0]     last_out_reg;
    logic                 out_seen_reg;
    logic                 out_hi_reg;
    logic                 outside_reg;
    logic                 above_reg;
    logic [SAMPLE_W-1:0]  ovs_diff_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [ALU_W-1:0] s_ext;
    logic [ALU_W-1:0] sp_ext;
    logic [ALU_W-1:0] peak_ext;
    logic [ALU_W-1:0] rem_ext;
    logic [ALU_W-1:0] s10;
    logic [ALU_W-1:0] s50;
    logic [ALU_W-1:0] sp9;
    logic [ALU_W-1:0] sp49;
    logic [ALU_W-1:0] sp51;
    logic [ALU_W-1:0] op_a;
    logic [ALU_W-1:0] op_b;
    logic             alu_ge;
    logic [ALU_W-1:0] alu_diff;
    logic             outside_now;
    logic             reached;
    logic [IDX_W-1:0] rise;
    logic [IDX_W-1:0] settle;
    logic [OVS_W-1:0] ovs;

    assign stat.accept     = s_tvalid && ctrl.ready;
    assign stat.final_flag = final_reg;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    srm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    assign s_ext    = {{(ALU_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign peak_ext = {{(ALU_W-SAMPLE_W){peak_reg[SAMPLE_W-1]}}, peak_reg};
    assign sp_ext   = {{(ALU_W-SP_W){1'b0}}, sp_reg};
    assign rem_ext  = {{(ALU_W-NUM_W){1'b0}}, rem_reg};
    assign s10      = s_ext * K10;
    assign s50      = s_ext * K50;
    assign sp9      = sp_ext * K9;
    assign sp49     = sp_ext * K49;
    assign sp51     = sp_ext * K51;

    // band test 50*|s - sp| > sp split into 50s > 51sp and 50s < 49sp
    always_comb begin
        unique case (ctrl.opsel)
            OPS_LOW: begin
                op_a = s10;
                op_b = sp_ext;
            end
            OPS_HIGH: begin
                op_a = s10;
                op_b = sp9;
            end
            OPS_OUT_HI: begin
                op_a = sp51;
                op_b = s50;
            end
            OPS_OUT_LO: begin
                op_a = s50;
                op_b = sp49;
            end
            OPS_PEAK: begin
                op_a = peak_ext;
                op_b = s_ext;
            end
            OPS_OVS: begin
                op_a = peak_ext;
                op_b = sp_ext;
            end
            OPS_DIV: begin
                op_a = rem_ext;
                op_b = sp_ext << ctrl.step;
            end
            default: begin
                op_a = s10;
                op_b = sp_ext;
            end
        endcase
    end

    srm_alu u_alu (
        .op_a (op_a),
        .op_b (op_b),
        .ge   (alu_ge),
        .diff (alu_diff)
    );

    assign outside_now = out_hi_reg || !alu_ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= SP_RESET;
        end else if (cfg_wr_en) begin
            sp_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.load_out) begin
            idx_reg       <= '0;
            low_idx_reg   <= '0;
            low_seen_reg  <= 1'b0;
            high_idx_reg  <= '0;
            high_seen_reg <= 1'b0;
            peak_reg      <= PEAK_RESET;
            last_out_reg  <= '0;
            out_seen_reg  <= 1'b0;
        end else begin
            if (ctrl.upd_low && !low_seen_reg && alu_ge) begin
                low_seen_reg <= 1'b1;
                low_idx_reg  <= idx_reg;
            end
            if (ctrl.upd_high && !high_seen_reg && alu_ge) begin
                high_seen_reg <= 1'b1;
                high_idx_reg  <= idx_reg;
            end
            if (ctrl.upd_out_lo && outside_now) begin
                out_seen_reg <= 1'b1;
                last_out_reg <= idx_reg;
            end
            if (ctrl.upd_peak) begin
                if (!alu_ge) peak_reg <= sample_reg;
                if (idx_reg != IDX_CAP) idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.accept) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            final_reg  <= s_tlast;
        end
        if (ctrl.upd_out_hi) out_hi_reg <= !alu_ge;
        if (ctrl.upd_out_lo) outside_reg <= outside_now;
        if (ctrl.ovs_cmp) begin
            above_reg    <= alu_ge && (alu_diff != '0);
            ovs_diff_reg <= alu_diff[SAMPLE_W-1:0];
        end
        if (ctrl.ovs_mul) begin
            rem_reg <= {{(NUM_W-SAMPLE_W){1'b0}}, ovs_diff_reg}
                     * {{(NUM_W-SCALE_W){1'b0}}, OVS_SCALE};
            quo_reg <= '0;
        end
        // restoring divide, top quotient bit flags saturation
        if (ctrl.div_step) begin
            if (alu_ge) rem_reg <= alu_diff[NUM_W-1:0];
            quo_reg <= {quo_reg[DIV_STEPS-2:0], alu_ge};
        end
    end

    assign reached = low_seen_reg && high_seen_reg;
    assign rise    = (reached && (high_idx_reg >= low_idx_reg))
                   ? high_idx_reg - low_idx_reg : '0;
    assign settle  = (!outside_reg && out_seen_reg) ? last_out_reg + 1'b1 : '0;
    assign ovs     = !above_reg ? '0
                   : quo_reg[DIV_STEPS-1] ? '1 : quo_reg[OVS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_tdata_reg <= {2'b00, ovs, peak_reg, !outside_reg, settle, reached, rise};
        end
    end

    assign s_tready = ctrl.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_cadence: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> (!s_tready ##4 !s_tready ##1 s_tready))
        else $error("non-final sample did not take five compare cycles");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending one");

    a_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |=> (!low_seen_reg && !high_seen_reg && !out_seen_reg
                           && (idx_reg == '0)))
        else $error("response state not cleared after result");

endmodule

// ===== tb/tb_step_response_metrics_core.sv =====
`timescale 1ns / 1ps

module tb_step_response_metrics_core;

    import srm_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam longint SAMPLE_MIN = -8388608;
    localparam longint SAMPLE_MAX = 8388607;

    typedef struct packed {
        logic [13:0] rise;
        logic        reached;
        logic [13:0] settle;
        logic        settled;
        logic [23:0] peak;
        logic [15:0] overshoot;
    } metrics_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // [23:0] sample
    logic                 s_tlast     = 1'b0; // final_sample
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    // [13:0] rise, [14] reached, [28:15] settle, [29] settled, [53:30] peak,
    // [69:54] overshoot, [71:70] zero
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en   = 1'b0;
    logic [SP_W-1:0]      cfg_wr_data = '0;

    // shadow copy of the block's setpoint and per-response measurements
    logic [SP_W-1:0]     setpoint_now   = SP_RESET;
    logic [IDX_W-1:0]    sample_pos     = '0;
    logic [IDX_W-1:0]    low_idx        = '0;
    logic [IDX_W-1:0]    high_idx       = '0;
    logic [IDX_W-1:0]    last_out_idx   = '0;
    logic                low_seen       = 1'b0;
    logic                high_seen      = 1'b0;
    logic                out_seen       = 1'b0;
    logic signed [23:0]  peak_so_far    = PEAK_RESET;

    metrics_t expected_metrics[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int stall_cycles  = 0;
    int samples_sent  = 0;

    step_response_metrics_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // updates the shadow state for one accepted sample, queues a result on the final one
    task automatic predict_metrics(input logic signed [23:0] s, input logic last);
        longint   sv;
        longint   sp;
        longint   dev;
        longint   pk;
        longint   q;
        logic     outside;
        metrics_t exp_m;
        sv  = s;
        sp  = longint'(setpoint_now);
        dev = sv - sp;
        if (dev < 0) begin
            dev = -dev;
        end
        outside = (50 * dev > sp);
        if (!low_seen && 10 * sv >= sp) begin
            low_seen = 1'b1;
            low_idx  = sample_pos;
        end
        if (!high_seen && 10 * sv >= 9 * sp) begin
            high_seen = 1'b1;
            high_idx  = sample_pos;
        end
        if (s > peak_so_far) begin
            peak_so_far = s;
        end
        if (outside) begin
            out_seen     = 1'b1;
            last_out_idx = sample_pos;
        end
        if (sample_pos < IDX_CAP) begin
            sample_pos = sample_pos + 1'b1;
        end
        if (last) begin
            exp_m.reached = low_seen && high_seen;
            exp_m.rise    = (exp_m.reached && high_idx >= low_idx) ? high_idx - low_idx : '0;
            exp_m.settle  = (!outside && out_seen) ? IDX_W'(last_out_idx + 1'b1) : '0;
            exp_m.settled = !outside;
            exp_m.peak    = peak_so_far;
            pk = peak_so_far;
            if (pk <= sp) begin
                q = 0;
            end else if (sp == 0) begin
                q = 65535;
            end else begin
                q = (pk - sp) * 10000 / sp;
                if (q > 65535) begin
                    q = 65535;
                end
            end
            exp_m.overshoot = q[15:0];
            expected_metrics.insert(expected_metrics.size(), exp_m);
            sample_pos   = '0;
            low_idx      = '0;
            high_idx     = '0;
            last_out_idx = '0;
            low_seen     = 1'b0;
            high_seen    = 1'b0;
            out_seen     = 1'b0;
            peak_so_far  = PEAK_RESET;
        end
    endtask

    // one request; valid stays up afterwards so back-to-back samples need no gap
    task automatic push_sample(input logic [23:0] raw, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_metrics(raw, last);
        samples_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_metrics.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_setpoint(input logic [SP_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        setpoint_now = value;
    endtask

    always @(posedge aclk) begin : check_results
        metrics_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_metrics.size() == 0) begin
                report_mismatch("unexpected result, peak", $signed(m_tdata[53:30]), 0);
            end else begin
                want = expected_metrics.pop_front();
                if (m_tdata[13:0] !== want.rise)
                    report_mismatch("rise_samples", m_tdata[13:0], want.rise);
                if (m_tdata[14] !== want.reached)
                    report_mismatch("rise_reached", m_tdata[14], want.reached);
                if (m_tdata[28:15] !== want.settle)
                    report_mismatch("settle_index", m_tdata[28:15], want.settle);
                if (m_tdata[29] !== want.settled)
                    report_mismatch("settled", m_tdata[29], want.settled);
                if (m_tdata[53:30] !== want.peak)
                    report_mismatch("peak_value", $signed(m_tdata[53:30]),
                                    $signed(want.peak));
                if (m_tdata[69:54] !== want.overshoot)
                    report_mismatch("overshoot_centipercent", m_tdata[69:54],
                                    want.overshoot);
                if (m_tdata[71:70] !== 2'b00)
                    report_mismatch("padding", m_tdata[71:70], 0);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_step_response_metrics_core NOT OK");
            $finish;
        end
    end

    // crossings, band edges, peak extremes, overshoot saturation, zero and max setpoint
    task automatic test_levels_and_extremes();
        // clean step: 10% at index 1, 90% at index 2, overshoot, settles in band
        push_sample(24'd0, 1'b0);
        push_sample(24'd6554, 1'b0);
        push_sample(24'd58983, 1'b0);
        push_sample(24'd70000, 1'b0);
        push_sample(24'd65536, 1'b1);
        // most negative: nothing reached, final outside band
        push_sample(24'h800000, 1'b1);
        // most positive: overshoot saturates
        push_sample(24'h7FFFFF, 1'b1);
        // always in band
        push_sample(24'd65536, 1'b1);
        // just outside, then just inside the 2% band
        push_sample(24'd66847, 1'b0);
        push_sample(24'd66846, 1'b1);
        write_setpoint('0);
        push_sample(24'd1, 1'b1);
        push_sample(24'd0, 1'b1);
        push_sample(24'hFFFFFF, 1'b1);
        write_setpoint({SP_W{1'b1}});
        push_sample(24'h7FFFFF, 1'b1);
        push_sample(24'd235929, 1'b0);
        push_sample(24'd262143, 1'b1);
        write_setpoint(18'd131072);
        push_sample(24'd13107, 1'b0);
        push_sample(24'd13108, 1'b0);
        push_sample(24'd131072, 1'b1);
        write_setpoint(SP_RESET);
    endtask

    // long slow rise: 10% crossing early, 90% crossing near the end
    task automatic test_long_response();
        write_setpoint(SP_RESET);
        for (int i = 0; i < 100; i++) begin
            if (i < 5) begin
                push_sample(24'd0, 1'b0);
            end else if (i < 98) begin
                push_sample(24'd13107, 1'b0);
            end else if (i == 98) begin
                push_sample(24'd60000, 1'b0);
            end else begin
                push_sample(24'd65536, 1'b1);
            end
        end
        drain_results();
    endtask

    // mostly step-like responses with random shape, some pure noise
    task automatic test_random_responses(input int target);
        int      len;
        int      rise_len;
        int      bump_pct;
        bit      noise;
        bit      end_in_band;
        longint  sp;
        longint  v;
        longint  amp;
        int      stop_at;
        stop_at = samples_sent + target;
        while (samples_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                case ($urandom_range(5))
                    0:       write_setpoint('0);
                    1:       write_setpoint(18'd131072);
                    2:       write_setpoint({SP_W{1'b1}});
                    3:       write_setpoint(SP_RESET);
                    default: write_setpoint(SP_W'($urandom_range(131072, 1)));
                endcase
            end else if ($urandom_range(99) < 10) begin
                drain_results();
            end
            sp          = longint'(setpoint_now);
            len         = ($urandom_range(19) == 0) ? $urandom_range(300, 100)
                                                    : $urandom_range(40, 1);
            noise       = ($urandom_range(4) == 0);
            rise_len    = $urandom_range(len);
            bump_pct    = $urandom_range(60);
            end_in_band = ($urandom_range(9) < 7);
            amp         = sp / 25 + 1;
            for (int i = 0; i < len; i++) begin
                if (noise) begin
                    push_sample(24'($urandom), (i == len - 1));
                end else begin
                    v = (i < rise_len) ? sp * i / rise_len : sp;
                    if (i >= rise_len && i < rise_len + 3) begin
                        v += sp * bump_pct / 100;
                    end
                    v += longint'($urandom_range(32'(2 * amp))) - amp;
                    if (i == len - 1 && end_in_band) begin
                        v = sp + longint'($urandom_range(32'(sp / 30))) - sp / 60;
                    end
                    if (v > SAMPLE_MAX) begin
                        v = SAMPLE_MAX;
                    end else if (v < SAMPLE_MIN) begin
                        v = SAMPLE_MIN;
                    end
                    push_sample(v[23:0], (i == len - 1));
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 28;
        recv_idle_pct = 62;
        test_levels_and_extremes();
        test_random_responses(160);

        drain_results();
        send_idle_pct = 62;
        recv_idle_pct = 28;
        test_random_responses(160);

        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_response();
        test_random_responses(160);

        drain_results();
        if (fail_count == 0) begin
            $display("tb_step_response_metrics_core OK");
        end else begin
            $display("tb_step_response_metrics_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== step_response_metrics_core.f =====
hw/rtl/srm_pkg.sv
hw/rtl/srm_alu.sv
hw/rtl/srm_ctrl.sv
hw/rtl/step_response_metrics_core.sv
tb/tb_step_response_metrics_core.sv
